/* rtl/pbps_pkg.sv */
// Package for the periodic bond pair search core: payload types, codes, shift table.
// No dependencies.
`timescale 1ns / 1ps
package pbps_pkg;

  localparam int unsigned MaxAtoms = 1024;
  localparam int unsigned IdxW = $clog2(MaxAtoms);
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [63:0] LowBoundRaw = 64'd597688;

  localparam logic [1:0] ModeClear  = 2'd0;
  localparam logic [1:0] ModeAppend = 2'd1;
  localparam logic [1:0] ModeFetch  = 2'd2;
  localparam logic [1:0] ModeUnused = 2'd3;

  localparam logic [1:0] RegCellA = 2'd0;
  localparam logic [1:0] RegCellB = 2'd1;
  localparam logic [1:0] RegCellC = 2'd2;
  localparam logic [1:0] RegCut   = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] pos_z;
    logic [11:0]        radius;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [9:0]  first_index;
    logic [9:0]  second_index;
    logic [2:0]  direction;
    logic [20:0] distance;
    logic        dropped;
  } rsp_t;

  // Shift coefficients for (a,b,c), each in {-1,0,1} as 2-bit signed.
  typedef struct packed {
    logic signed [1:0] ca;
    logic signed [1:0] cb;
    logic signed [1:0] cc;
  } coef_t;

  function automatic coef_t shift_coef(input logic [2:0] dir, input logic [1:0] s);
    coef_t c;
    c = '{ca: 2'sd0, cb: 2'sd0, cc: 2'sd0};
    case (dir)
      3'd1: c.ca = 2'sd1;
      3'd2: c.cb = 2'sd1;
      3'd3: begin c.ca = 2'sd1; c.cb = (s[0]) ? -2'sd1 : 2'sd1; end
      3'd4: c.cc = 2'sd1;
      3'd5: begin c.ca = 2'sd1; c.cc = (s[0]) ? -2'sd1 : 2'sd1; end
      3'd6: begin c.cb = 2'sd1; c.cc = (s[0]) ? -2'sd1 : 2'sd1; end
      3'd7: begin
        case (s)
          2'd0: c = '{ca: 2'sd1, cb: 2'sd1, cc: 2'sd1};
          2'd1: c = '{ca: 2'sd1, cb: 2'sd1, cc: -2'sd1};
          2'd2: c = '{ca: 2'sd1, cb: -2'sd1, cc: 2'sd1};
          default: c = '{ca: -2'sd1, cb: 2'sd1, cc: 2'sd1};
        endcase
      end
      default: c = '{ca: 2'sd0, cb: 2'sd0, cc: 2'sd0};
    endcase
    return c;
  endfunction

  function automatic logic [2:0] shift_count(input logic [2:0] dir);
    logic [2:0] n;
    case (dir)
      3'd3, 3'd5, 3'd6: n = 3'd2;
      3'd7: n = 3'd4;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

endpackage

/* rtl/periodic_bond_pair_search_core.sv */
// Periodic bond pair search core: atom store, pair scan sequencer, shared
// multiply/accumulate unit and bit-serial square root. Uses pbps_pkg.
`timescale 1ns / 1ps
// Usage:
//  Request channel (req_valid_i/req_ready_o, req_i) carries mode and atom data.
//  A clear acts when taken, an append passes S_APP; neither answers. A fetch
//  walks the pair scan (direction, shift, i, j) and gives exactly one response
//  on rsp_valid_o/rsp_ready_i: the next bond with its length, or found=0 once
//  the scan is finished.
//  An index pair that fails the i/j order test is skipped in S_CHK. A tested
//  pair passes the index check, two store reads, three diff/square rounds on
//  the single shared multiplier accumulating |d|^2, the cutoff product and its
//  square, and the compare. A hit adds a 24-step bit-serial square root and
//  the output state. A fetch on a finished scan answers after S_CHK and S_OUT.
//  Config writes (cfg_we_i, cfg_idx_i, cfg_data_i) restart the scan. The user
//  must see that they are written only while the block is idle; it is not enforced.
//  Reset empties the atom set, clears the dropped flag and loads the unit
//  cell vectors and cut factor 282. The atom memory is not cleared.
//  While the response is not taken, the core holds it and takes no request.
module periodic_bond_pair_search_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  pbps_pkg::req_t     req_i,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output pbps_pkg::rsp_t     rsp_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [59:0]        cfg_data_i
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_APP   = 11'b00000000010,
    S_CHK   = 11'b00000000100,
    S_RDI   = 11'b00000001000,
    S_RDJ   = 11'b00000010000,
    S_DIFF  = 11'b00000100000,
    S_MUL   = 11'b00001000000,
    S_CUT   = 11'b00010000000,
    S_CMP   = 11'b00100000000,
    S_SQRT  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_e;

  localparam int unsigned IW = pbps_pkg::IdxW;
  localparam int unsigned CW = pbps_pkg::CntW;

  state_e state_q, state_d;

  logic [59:0] cell_a_q, cell_b_q, cell_c_q;
  logic [9:0]  cut_q;
  logic [CW-1:0] count_q;
  logic        ovf_q;
  logic [2:0]  dir_q;
  logic [1:0]  sh_q;
  logic [IW-1:0] fi_q, se_q;
  logic        done_q;

  logic [59:0] pos_mem [pbps_pkg::MaxAtoms];
  logic [11:0] rad_mem [pbps_pkg::MaxAtoms];
  logic [59:0] rd_pos_q;
  logic [11:0] rd_rad_q;
  logic [IW-1:0] rd_addr;
  logic        mem_we;

  logic [59:0] pos_i_q;
  logic [11:0] rad_i_q, rad_j_q;
  logic [59:0] pos_j_q;
  logic [1:0]  k_q;
  logic signed [23:0] diff_q;
  logic [47:0] sum_q;
  logic [63:0] effsq_q;
  logic [22:0] eff_q;
  logic        cut_ph_q;

  logic [47:0] rem_q;
  logic [23:0] root_q;
  logic [4:0]  sq_cnt_q;

  pbps_pkg::rsp_t rsp_q;
  logic rsp_v_q;

  logic restart;

  // ---- shared multiplier (one per cycle) ----
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic signed [19:0] ci, cj, va, vb, vc;
  pbps_pkg::coef_t co;
  logic signed [23:0] dsum;
  // coefficient bit0: nonzero, bit1: negative
  always_comb begin
    ci = pos_i_q[20*k_q +: 20];
    cj = pos_j_q[20*k_q +: 20];
    va = cell_a_q[20*k_q +: 20];
    vb = cell_b_q[20*k_q +: 20];
    vc = cell_c_q[20*k_q +: 20];
    co = pbps_pkg::shift_coef(dir_q, sh_q);
    dsum = 24'(ci) - 24'(cj);
    if (co.ca[0]) dsum = co.ca[1] ? dsum - 24'(va) : dsum + 24'(va);
    if (co.cb[0]) dsum = co.cb[1] ? dsum - 24'(vb) : dsum + 24'(vb);
    if (co.cc[0]) dsum = co.cc[1] ? dsum - 24'(vc) : dsum + 24'(vc);
  end

  logic [23:0] absd;
  assign absd = diff_q[23] ? 24'(-diff_q) : 24'(diff_q);

  always_comb begin
    mul_a = 32'(absd);
    mul_b = 32'(absd);
    if (state_q == S_CUT) begin
      if (!cut_ph_q) begin
        mul_a = 32'(13'(rad_i_q) + 13'(rad_j_q));
        mul_b = 32'(cut_q);
      end else begin
        mul_a = 32'(eff_q);
        mul_b = 32'(eff_q);
      end
    end
  end

  // ---- pair predicates ----
  logic last_j, last_i, last_s, last_d;
  logic [2:0] n_sh;
  assign n_sh = pbps_pkg::shift_count(dir_q);
  assign last_j = (CW'(se_q) + CW'(1)) >= count_q;
  assign last_i = (CW'(fi_q) + CW'(1)) >= count_q;
  assign last_s = ({1'b0, sh_q} + 3'd1) >= n_sh;
  assign last_d = (dir_q == 3'd7);
  logic skip_idx;
  assign skip_idx = (fi_q == se_q) || (dir_q == 3'd0 && se_q < fi_q);

  assign rd_addr = (state_q == S_CHK) ? fi_q : se_q;
  assign mem_we = (state_q == S_APP) && (count_q < CW'(pbps_pkg::MaxAtoms));

  logic [IW-1:0] wr_addr;
  pbps_pkg::req_t req_q;
  assign wr_addr = count_q[IW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pos_mem[wr_addr] <= {req_q.pos_z, req_q.pos_y, req_q.pos_x};
      rad_mem[wr_addr] <= req_q.radius;
    end
    rd_pos_q <= pos_mem[rd_addr];
    rd_rad_q <= rad_mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (req_valid_i) begin
        unique case (req_i.mode)
          pbps_pkg::ModeAppend: state_d = S_APP;
          pbps_pkg::ModeFetch:  state_d = S_CHK;
          default:              state_d = S_IDLE;
        endcase
      end
      S_APP:  state_d = S_IDLE;
      S_CHK:  state_d = (done_q || count_q == '0) ? S_OUT :
                        (skip_idx ? S_CHK : S_RDI);
      S_RDI:  state_d = S_RDJ;
      S_RDJ:  state_d = S_DIFF;
      S_DIFF: state_d = S_MUL;
      S_MUL:  state_d = (k_q == 2'd2) ? S_CUT : S_DIFF;
      S_CUT:  state_d = cut_ph_q ? S_CMP : S_CUT;
      S_CMP:  state_d = (rad_i_q != '0 && rad_j_q != '0 && 64'(sum_q) > pbps_pkg::LowBoundRaw
                         && {4'd0, sum_q, 12'd0} < effsq_q) ? S_SQRT : S_CHK;
      S_SQRT: state_d = (sq_cnt_q == 5'd23) ? S_OUT : S_SQRT;
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign req_ready_o = (state_q == S_IDLE) && !rsp_v_q;
  assign restart = cfg_we_i ||
                   (state_q == S_IDLE && req_valid_i && !rsp_v_q &&
                    (req_i.mode == pbps_pkg::ModeClear || req_i.mode == pbps_pkg::ModeAppend));

  logic adv;
  assign adv = (state_q == S_CHK && !(done_q || count_q == '0) && skip_idx) ||
               (state_q == S_CMP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cell_a_q <= 60'd1024;
      cell_b_q <= 60'd1073741824;
      cell_c_q <= 60'd1099511627776;
      cut_q    <= 10'd282;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      dir_q    <= '0;
      sh_q     <= '0;
      fi_q     <= '0;
      se_q     <= '0;
      done_q   <= 1'b0;
      rsp_v_q  <= 1'b0;
    end else begin
      state_q <= (state_q == S_IDLE && rsp_v_q) ? S_IDLE : state_d;
      if (state_q == S_OUT) rsp_v_q <= 1'b1;
      else if (rsp_v_q && rsp_ready_i) rsp_v_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pbps_pkg::RegCellA: cell_a_q <= cfg_data_i;
          pbps_pkg::RegCellB: cell_b_q <= cfg_data_i;
          pbps_pkg::RegCellC: cell_c_q <= cfg_data_i;
          pbps_pkg::RegCut:   cut_q    <= cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (req_ready_o && req_valid_i && req_i.mode == pbps_pkg::ModeClear) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end
      if (state_q == S_APP) begin
        if (mem_we) count_q <= count_q + CW'(1);
        else        ovf_q   <= 1'b1;
      end
      if (restart) begin
        dir_q <= '0; sh_q <= '0; fi_q <= '0; se_q <= '0; done_q <= 1'b0;
      end else if (adv) begin
        if (!last_j) se_q <= se_q + IW'(1);
        else begin
          se_q <= '0;
          if (!last_i) fi_q <= fi_q + IW'(1);
          else begin
            fi_q <= '0;
            if (!last_s) sh_q <= sh_q + 2'd1;
            else begin
              sh_q <= '0;
              if (!last_d) dir_q <= dir_q + 3'd1;
              else begin
                dir_q  <= '0;
                done_q <= 1'b1;
              end
            end
          end
        end
      end else if (state_q == S_CHK && count_q == '0) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_ready_o && req_valid_i) req_q <= req_i;
    if (state_q == S_CHK) begin
      rsp_q.first_index  <= 10'(fi_q);
      rsp_q.second_index <= 10'(se_q);
      rsp_q.direction    <= dir_q;
      rsp_q.found        <= !(done_q || count_q == '0);
      rsp_q.distance     <= '0;
      rsp_q.dropped      <= ovf_q;
      k_q                <= '0;
      sum_q              <= '0;
      cut_ph_q           <= 1'b0;
    end
    if (state_q == S_RDI) begin
      pos_i_q <= rd_pos_q;
      rad_i_q <= rd_rad_q;
    end
    if (state_q == S_RDJ) begin
      pos_j_q <= rd_pos_q;
      rad_j_q <= rd_rad_q;
    end
    if (state_q == S_DIFF) diff_q <= dsum;
    if (state_q == S_MUL) begin
      sum_q <= sum_q + mul_p[47:0];
      k_q   <= k_q + 2'd1;
    end
    if (state_q == S_CUT) begin
      if (!cut_ph_q) eff_q <= mul_p[22:0];
      else effsq_q <= mul_p;
      cut_ph_q <= 1'b1;
    end
    if (state_q == S_CMP) begin
      rem_q    <= sum_q;
      root_q   <= '0;
      sq_cnt_q <= '0;
    end
    if (state_q == S_SQRT) begin
      // one result bit per cycle, from the top pair of remainder bits
      if (50'(rem_q >> (2*(23-sq_cnt_q))) >= 50'({root_q, 2'b01})) begin
        rem_q  <= rem_q - 48'(50'({root_q, 2'b01}) << (2*(23-sq_cnt_q)));
        root_q <= {root_q[22:0], 1'b1};
      end else begin
        root_q <= {root_q[22:0], 1'b0};
      end
      sq_cnt_q <= sq_cnt_q + 5'd1;
      if (sq_cnt_q == 5'd23) rsp_q.distance <= 21'({root_q[22:0], 1'b0} |
        24'(50'(rem_q >> 0) >= 50'({root_q, 2'b01})));
    end
  end

  assign rsp_valid_o = rsp_v_q;
  assign rsp_o       = rsp_q;

  property p_busy_not_ready;
    @(posedge clk_i) disable iff (!rst_ni) (state_q != S_IDLE) |-> !req_ready_o;
  endproperty
  assert property (p_busy_not_ready) else $error("ready while busy");

  property p_done_no_found;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_CHK && (done_q || count_q == '0)) |=> !rsp_o.found;
  endproperty
  assert property (p_done_no_found) else $error("found after scan end");

  property p_count_bound;
    @(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(pbps_pkg::MaxAtoms);
  endproperty
  assert property (p_count_bound) else $error("atom count overflow");

endmodule
